### src/tphf_pkg.sv
`timescale 1ns / 1ps
package tphf_pkg;

	localparam int MAX_TOUCHES   = 4;
	localparam int PAIRS_CARRIED = 4;
	localparam int TC_LIMIT      = (MAX_TOUCHES < PAIRS_CARRIED) ? MAX_TOUCHES : PAIRS_CARRIED;

	localparam logic [6:0]  HOLD_LIMIT   = 7'd120;
	localparam logic [6:0]  HOLD_DEFAULT = 7'd10;
	localparam logic [15:0] OFF_SCREEN   = 16'h7fff;
	localparam int          SCREEN_HALF  = 80;

	// reciprocal divide of an 18-bit magnitude by the touch count
	localparam int SUM_W     = 18;
	localparam int DIV_SHIFT = 18;
	localparam int RECIP_W   = 19;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam int QUOT_W    = 17;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTER_IS_MOUSE = 2'd1;

	typedef struct packed {
		logic        [2:0]  touch_count;
		logic signed [15:0] touch_x0;
		logic signed [15:0] touch_y0;
		logic signed [15:0] touch_x1;
		logic signed [15:0] touch_y1;
		logic signed [15:0] touch_x2;
		logic signed [15:0] touch_y2;
		logic signed [15:0] touch_x3;
		logic signed [15:0] touch_y3;
		logic        [2:0]  mouse_buttons;
	} req_t;

	typedef struct packed {
		logic [7:0] pointer_x;
		logic [7:0] pointer_y;
		logic [2:0] button_bits;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_SEL,
		ST_SCALE
	} state_t;

	typedef struct packed {
		logic load;
		logic acc;
		logic div;
		logic commit;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic sum_done;
		logic out_full;
	} sts_t;

	// ceil(2^18 / n); exact quotient for every sum the touch count allows
	function automatic logic [RECIP_W-1:0] recip(input logic [2:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			3'd1:    r = 19'd262144;
			3'd2:    r = 19'd131072;
			3'd3:    r = 19'd87382;
			3'd4:    r = 19'd65536;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### src/tphf_ctrl.sv
`timescale 1ns / 1ps
module tphf_ctrl import tphf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  sts_t sts,
	output logic req_stall,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_SUM;
			end
			ST_SUM: begin
				if (sts.sum_done) state_d = ST_DIV;
			end
			ST_DIV:   state_d = ST_SEL;
			ST_SEL:   state_d = ST_SCALE;
			ST_SCALE: begin
				if (!sts.out_full) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			ST_SUM:   cmd.acc    = !sts.sum_done;
			ST_DIV:   cmd.div    = 1'b1;
			ST_SEL:   cmd.commit = 1'b1;
			ST_SCALE: cmd.emit   = !sts.out_full;
			default:  cmd = '0;
		endcase
	end

endmodule

### src/tphf_dp.sv
`timescale 1ns / 1ps
module tphf_dp import tphf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  rsp_stall,
	output logic                  rsp_valid,
	output rsp_t                  rsp
);

	// 80 + 80*p/32767 toward zero; divide by 2^15-1 as shift plus one correction
	function automatic logic [7:0] scale_axis(input logic signed [15:0] p);
		logic [15:0] mag;
		logic [21:0] m;
		logic [6:0]  q0;
		logic [15:0] r;
		logic [6:0]  q;
		mag = p[15] ? (~p + 16'd1) : p;
		m   = 22'(mag) * 22'(SCREEN_HALF);
		q0  = m[21:15];
		r   = {1'b0, m[14:0]} + 16'(q0);
		q   = (r >= OFF_SCREEN) ? (q0 + 7'd1) : q0;
		return p[15] ? (8'(SCREEN_HALF) - 8'(q)) : (8'(SCREEN_HALF) + 8'(q));
	endfunction

	logic [6:0] hold_frames_q;
	logic       mouse_q;

	req_t                    req_q;
	logic        [2:0]       tc_q;
	logic        [2:0]       idx_q;
	logic signed [SUM_W-1:0] sx_q;
	logic signed [SUM_W-1:0] sy_q;
	logic        [QUOT_W-1:0] qx_q;
	logic        [QUOT_W-1:0] qy_q;
	logic                    negx_q;
	logic                    negy_q;
	logic signed [15:0]      pos_x_q;
	logic signed [15:0]      pos_y_q;
	logic        [2:0]       btn_q;

	logic [6:0]         pos_cd_q;
	logic [2:0]         pos_tc_q;
	logic signed [15:0] held_x_q;
	logic signed [15:0] held_y_q;
	logic [2:0]         pend_tc_q;
	logic [6:0]         cnt_cd_q;
	logic [2:0]         stable_tc_q;

	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [2:0]         tc_sat;
	logic signed [15:0] pair_x;
	logic signed [15:0] pair_y;
	logic [SUM_W-1:0]   mag_x;
	logic [SUM_W-1:0]   mag_y;
	logic [PROD_W-1:0]  prod_x;
	logic [PROD_W-1:0]  prod_y;
	logic signed [15:0] avg_x;
	logic signed [15:0] avg_y;
	logic               hold;
	logic signed [15:0] px;
	logic signed [15:0] py;
	logic [6:0]         cd_dec;
	logic [2:0]         ptc_dec;
	logic [2:0]         stable_d;

	assign tc_sat = (req.touch_count > 3'(TC_LIMIT)) ? 3'(TC_LIMIT) : req.touch_count;

	always_comb begin
		case (idx_q[1:0])
			2'd0:    begin pair_x = req_q.touch_x0; pair_y = req_q.touch_y0; end
			2'd1:    begin pair_x = req_q.touch_x1; pair_y = req_q.touch_y1; end
			2'd2:    begin pair_x = req_q.touch_x2; pair_y = req_q.touch_y2; end
			default: begin pair_x = req_q.touch_x3; pair_y = req_q.touch_y3; end
		endcase
	end

	assign mag_x  = sx_q[SUM_W-1] ? (~sx_q + 18'd1) : sx_q;
	assign mag_y  = sy_q[SUM_W-1] ? (~sy_q + 18'd1) : sy_q;
	assign prod_x = PROD_W'(mag_x) * PROD_W'(recip(tc_q));
	assign prod_y = PROD_W'(mag_y) * PROD_W'(recip(tc_q));

	assign avg_x = negx_q ? 16'(~qx_q + 17'd1) : 16'(qx_q);
	assign avg_y = negy_q ? 16'(~qy_q + 17'd1) : 16'(qy_q);

	// hold the latched position while fingers are being lifted
	assign hold = (pos_cd_q != 7'd0) && (tc_q < pos_tc_q);

	always_comb begin
		if (hold) begin
			px = held_x_q;
			py = held_y_q;
		end else if (tc_q != 3'd0) begin
			px = avg_x;
			py = avg_y;
		end else if (mouse_q) begin
			px = req_q.touch_x0;
			py = req_q.touch_y0;
		end else begin
			px = OFF_SCREEN;
			py = OFF_SCREEN;
		end
	end

	assign cd_dec   = hold ? (pos_cd_q - 7'd1) : pos_cd_q;
	assign ptc_dec  = (cd_dec == 7'd0) ? 3'd0 : pos_tc_q;
	assign stable_d = ((tc_q == pend_tc_q) && (cnt_cd_q == 7'd0)) ? tc_q : stable_tc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_frames_q <= HOLD_DEFAULT;
			mouse_q       <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HOLD_FRAMES:      hold_frames_q <= (cfg_data > HOLD_LIMIT) ? HOLD_DEFAULT : cfg_data;
				CFG_POINTER_IS_MOUSE: mouse_q <= cfg_data[0];
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			tc_q  <= tc_sat;
			idx_q <= 3'd0;
			sx_q  <= '0;
			sy_q  <= '0;
		end
		if (cmd.acc) begin
			sx_q  <= sx_q + {{2{pair_x[15]}}, pair_x};
			sy_q  <= sy_q + {{2{pair_y[15]}}, pair_y};
			idx_q <= idx_q + 3'd1;
		end
		if (cmd.div) begin
			qx_q   <= prod_x[DIV_SHIFT +: QUOT_W];
			qy_q   <= prod_y[DIV_SHIFT +: QUOT_W];
			negx_q <= sx_q[SUM_W-1];
			negy_q <= sy_q[SUM_W-1];
		end
		if (cmd.commit) begin
			pos_x_q <= px;
			pos_y_q <= py;
			btn_q   <= req_q.mouse_buttons | {stable_d >= 3'd3, stable_d == 3'd2,
				stable_d == 3'd1};
		end
		if (cmd.emit) begin
			rsp_q.pointer_x   <= scale_axis(pos_x_q);
			rsp_q.pointer_y   <= scale_axis(pos_y_q);
			rsp_q.button_bits <= btn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cd_q    <= '0;
			pos_tc_q    <= '0;
			held_x_q    <= '0;
			held_y_q    <= '0;
			pend_tc_q   <= '0;
			cnt_cd_q    <= '0;
			stable_tc_q <= '0;
		end else if (cmd.commit) begin
			if (tc_q > ptc_dec) begin
				pos_cd_q <= hold_frames_q;
				pos_tc_q <= tc_q;
				held_x_q <= px;
				held_y_q <= py;
			end else begin
				pos_cd_q <= cd_dec;
				pos_tc_q <= ptc_dec;
			end
			if (tc_q == pend_tc_q) begin
				if (cnt_cd_q != 7'd0) begin
					cnt_cd_q <= cnt_cd_q - 7'd1;
				end else begin
					stable_tc_q <= tc_q;
				end
			end else begin
				pend_tc_q <= tc_q;
				cnt_cd_q  <= hold_frames_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.sum_done = (idx_q == tc_q);
	assign sts.out_full = rsp_valid_q && rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

### src/touch_to_pointer_hold_filter_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    req_t: touch count, 4 pairs, mouse buttons
// rsp       out        rsp_valid / rsp_stall    rsp_t: pointer_x, pointer_y, button_bits
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// After a request is accepted the filter adds one coordinate pair at a time,
// sees the count reached, then divides, selects and scales; rsp_valid rises
// when the scaled result is registered. The next request is accepted once the
// result sits in the output register, not while one is in flight. A stalled result
// holds there and delays the next result only. Reset clears the filter state
// and loads the register defaults (hold_frames 10, pointer_is_mouse 1).
module touch_to_pointer_hold_filter_top import tphf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tphf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	tphf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one in flight");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.acc, cmd.div, cmd.commit, cmd.emit}))
		else $error("more than one datapath command");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(rsp_valid && rsp_stall))
		else $error("result overwritten while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.pointer_x <= 8'd160) && (rsp.pointer_y <= 8'd160))
		else $error("pointer out of screen range");

endmodule
